[rtl/ads_pkg.sv]
package ads_pkg;

   // Field widths
   localparam int SENSE_W   = 12;
   localparam int STACKS_W  = 4;
   localparam int TOL_W     = 10;
   localparam int TICKS_W   = 16;
   localparam int RETRY_W   = 2;
   localparam int ANT_W     = 2;
   localparam int STATUS_W  = 3;
   localparam int CLASS_W   = 2;

   // Hold counter width and the width used for its end-of-hold compare
   localparam int HOLD_BITS  = 16;
   localparam int HOLD_CMP_W = (HOLD_BITS + 1 > TICKS_W) ? HOLD_BITS + 1 : TICKS_W;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRIES = 2'd2;

   // Register reset values
   localparam logic [TOL_W-1:0]   TOL_RESET     = 10'd200;
   localparam logic [TICKS_W-1:0] TICKS_RESET   = 16'd1000;
   localparam logic [RETRY_W-1:0] RETRIES_RESET = 2'd2;

   // Tolerance window; anything outside falls back to the minimum
   localparam logic [TOL_W-1:0] TOL_MIN = 10'd200;
   localparam logic [TOL_W-1:0] TOL_MAX = 10'd400;

   // Band edges in mV before the tolerance is taken off
   localparam logic [SENSE_W-1:0] EDGE_LOW  = 12'd660;
   localparam logic [SENSE_W-1:0] EDGE_MID  = 12'd1650;
   localparam logic [SENSE_W-1:0] EDGE_HIGH = 12'd3300;

   // Minimum stack count that allows a deployment is one more than this
   localparam logic [STACKS_W-1:0] STACKS_REFUSE_MAX = 4'd1;

   // Sense classes
   localparam logic [CLASS_W-1:0] CLS_NONE = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_ONE  = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_TWO  = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_BOTH = 2'd3;

   // Antenna numbers
   localparam logic [ANT_W-1:0] ANT_NONE = 2'd0;
   localparam logic [ANT_W-1:0] ANT_ONE  = 2'd1;
   localparam logic [ANT_W-1:0] ANT_TWO  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 3'd4;

   // Request operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

endpackage

[rtl/ads_if.sv]
// Request channel: start or tick beats
interface ads_req_if
   import ads_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                op;
   logic [SENSE_W-1:0]  sense_mv;
   logic [STACKS_W-1:0] battery_stacks;

   modport source (output valid, output op, output sense_mv, output battery_stacks,
                   input ready);
   modport sink   (input valid, input op, input sense_mv, input battery_stacks,
                   output ready);
endinterface

// Response channel: one beat per request beat
interface ads_rsp_if
   import ads_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic                rail_enable;
   logic                burn_one;
   logic                burn_two;
   logic [ANT_W-1:0]    active_antenna;
   logic [STATUS_W-1:0] deploy_status;
   logic                finished;
   logic                busy_res;

   modport source (output valid, output rail_enable, output burn_one, output burn_two,
                   output active_antenna, output deploy_status, output finished,
                   output busy_res, input ready);
   modport sink   (input valid, input rail_enable, input burn_one, input burn_two,
                   input active_antenna, input deploy_status, input finished,
                   input busy_res, output ready);
endinterface

[rtl/antenna_deploy_sequencer_top.sv]
// Burn-wire antenna deployment sequencer. Each request beat (a start, or a tick
// carrying a sense sample) produces exactly one response beat with the line levels,
// the antenna under attempt, the deployment status and the finished/busy flags as
// they stand after that beat. The sequencer state is updated in the cycle the beat
// is accepted and the response is held in an output register, so one beat is
// accepted every clock cycle unless the response stalls; req ready is high whenever
// the output register is empty or being emptied in the same cycle, and the response
// appears in the cycle after acceptance. The user must write the csr registers
// (tolerance, hold length, retry limit) only while no sequence is running, which the block does not enforce.
module antenna_deploy_sequencer_top
   import ads_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ads_req_if.sink               req_bus,
   ads_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SENSE,
      PH_HOLD_ON,
      PH_HOLD_OFF,
      PH_GAP
   } phase_type;

   // Configuration registers
   logic [TOL_W-1:0]   tolerance_ff;
   logic [TICKS_W-1:0] hold_ticks_ff;
   logic [RETRY_W-1:0] max_retries_ff;

   // Sequencer state
   phase_type            phase_ff,    phase_in;
   logic [RETRY_W-1:0]   attempt_ff,  attempt_in;
   logic [HOLD_BITS-1:0] hold_ff,     hold_in;
   logic [CLASS_W-1:0]   baseline_ff, baseline_in;
   logic                 dep_one_ff,  dep_one_in;
   logic                 dep_two_ff,  dep_two_in;
   logic [CLASS_W-1:0]   status_ff,   status_in;
   logic                 rail_ff,     rail_in;
   logic                 burn_one_ff, burn_one_in;
   logic                 burn_two_ff, burn_two_in;
   logic [ANT_W-1:0]     ant_ff,      ant_in;

   // Response register
   logic                 rsp_valid_ff;
   logic                 rsp_finished_ff, finished_in;
   logic [STATUS_W-1:0]  rsp_status_ff,   status_out_in;

   logic accept;
   logic [TOL_W-1:0]   tol_eff;
   logic [SENSE_W-1:0] thr_low, thr_mid, thr_high;
   logic [CLASS_W-1:0] sense_cls;
   logic               hold_end;
   logic [HOLD_CMP_W-1:0] hold_next_cmp;

   // Control scratch for the next-state logic
   logic               do_classify;
   logic               do_top;
   logic [ANT_W-1:0]   top_ant;
   logic               do_leave;
   logic [ANT_W-1:0]   leave_ant;
   logic               refused;
   logic               top_done;
   logic [ANT_W-1:0]   loop_ant;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Band edges with the effective tolerance taken off
   assign tol_eff  = (tolerance_ff >= TOL_MIN && tolerance_ff <= TOL_MAX) ?
                     tolerance_ff : TOL_MIN;
   assign thr_low  = EDGE_LOW  - SENSE_W'(tol_eff);
   assign thr_mid  = EDGE_MID  - SENSE_W'(tol_eff);
   assign thr_high = EDGE_HIGH - SENSE_W'(tol_eff);

   always_comb begin
      if (req_bus.sense_mv < thr_low) begin
         sense_cls = CLS_NONE;
      end else if (req_bus.sense_mv < thr_mid) begin
         sense_cls = CLS_ONE;
      end else if (req_bus.sense_mv < thr_high) begin
         sense_cls = CLS_TWO;
      end else begin
         sense_cls = CLS_BOTH;
      end
   end

   // Hold tick: ends on the programmed length or when the counter saturates
   assign hold_next_cmp = HOLD_CMP_W'(hold_ff) + HOLD_CMP_W'(1);
   assign hold_end      = (hold_next_cmp >= HOLD_CMP_W'(hold_ticks_ff)) || (&hold_ff);

   assign loop_ant = (ant_ff == ANT_TWO) ? ANT_TWO : ANT_ONE;

   // Next state for one accepted beat
   always_comb begin
      phase_in    = phase_ff;
      attempt_in  = attempt_ff;
      hold_in     = hold_ff;
      baseline_in = baseline_ff;
      dep_one_in  = dep_one_ff;
      dep_two_in  = dep_two_ff;
      status_in   = status_ff;
      rail_in     = rail_ff;
      burn_one_in = burn_one_ff;
      burn_two_in = burn_two_ff;
      ant_in      = ant_ff;
      finished_in = 1'b0;
      refused     = 1'b0;
      do_classify = 1'b0;
      do_top      = 1'b0;
      top_ant     = ANT_ONE;
      do_leave    = 1'b0;
      leave_ant   = ANT_ONE;
      top_done    = 1'b0;

      if (req_bus.op == OP_START) begin
         if (phase_ff == PH_IDLE) begin
            if (req_bus.battery_stacks <= STACKS_REFUSE_MAX) begin
               refused     = 1'b1;
               finished_in = 1'b1;
            end else begin
               do_classify = 1'b1;
               baseline_in = sense_cls;
               attempt_in  = '0;
               hold_in     = '0;
               rail_in     = 1'b1;
               burn_one_in = 1'b0;
               burn_two_in = 1'b0;
               do_top      = 1'b1;
               top_ant     = ANT_ONE;
            end
         end
      end else begin
         case (phase_ff)
            PH_SENSE: begin
               do_classify = 1'b1;
               if (sense_cls != baseline_ff || attempt_ff == max_retries_ff) begin
                  do_leave  = 1'b1;
                  leave_ant = loop_ant;
               end else begin
                  attempt_in = attempt_ff + RETRY_W'(1);
                  hold_in    = '0;
                  phase_in   = PH_HOLD_ON;
               end
            end
            PH_HOLD_ON: begin
               hold_in = hold_end ? '0 : hold_ff + HOLD_BITS'(1);
               if (hold_end) begin
                  burn_one_in = 1'b0;
                  burn_two_in = 1'b0;
                  phase_in    = PH_HOLD_OFF;
               end
            end
            PH_HOLD_OFF: begin
               hold_in = hold_end ? '0 : hold_ff + HOLD_BITS'(1);
               do_top  = hold_end;
               top_ant = loop_ant;
            end
            PH_GAP: begin
               hold_in = hold_end ? '0 : hold_ff + HOLD_BITS'(1);
               do_top  = hold_end;
               top_ant = ANT_TWO;
            end
            default: begin
            end
         endcase
      end

      // Classification sets sticky flags; the lowest band leaves the status alone
      if (do_classify) begin
         if (sense_cls != CLS_NONE) begin
            status_in = sense_cls;
         end
         if (sense_cls == CLS_ONE || sense_cls == CLS_BOTH) begin
            dep_one_in = 1'b1;
         end
         if (sense_cls == CLS_TWO || sense_cls == CLS_BOTH) begin
            dep_two_in = 1'b1;
         end
      end

      // Top of an antenna loop: skip if already deployed, else burn
      if (do_top) begin
         top_done = (top_ant == ANT_ONE) ? dep_one_in : dep_two_in;
         if (top_done) begin
            do_leave  = 1'b1;
            leave_ant = top_ant;
         end else begin
            ant_in   = top_ant;
            phase_in = PH_SENSE;
            if (top_ant == ANT_ONE) begin
               burn_one_in = 1'b1;
            end else begin
               burn_two_in = 1'b1;
            end
         end
      end

      // Leave an antenna: gap after the first, end of sequence after the second
      if (do_leave) begin
         ant_in     = ANT_NONE;
         attempt_in = '0;
         hold_in    = '0;
         if (leave_ant == ANT_ONE) begin
            burn_one_in = 1'b0;
            phase_in    = PH_GAP;
         end else begin
            burn_two_in = 1'b0;
            rail_in     = 1'b0;
            phase_in    = PH_IDLE;
            finished_in = 1'b1;
         end
      end

      status_out_in = refused ? STATUS_REFUSED : STATUS_W'(status_in);
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff   <= TOL_RESET;
         hold_ticks_ff  <= TICKS_RESET;
         max_retries_ff <= RETRIES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOLERANCE:   tolerance_ff   <= csr_wdata[TOL_W-1:0];
            CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_wdata[TICKS_W-1:0];
            CSR_MAX_RETRIES: max_retries_ff <= csr_wdata[RETRY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state, updated on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         attempt_ff  <= '0;
         hold_ff     <= '0;
         baseline_ff <= CLS_NONE;
         dep_one_ff  <= 1'b0;
         dep_two_ff  <= 1'b0;
         status_ff   <= CLS_NONE;
         rail_ff     <= 1'b0;
         burn_one_ff <= 1'b0;
         burn_two_ff <= 1'b0;
         ant_ff      <= ANT_NONE;
      end else if (accept) begin
         phase_ff    <= phase_in;
         attempt_ff  <= attempt_in;
         hold_ff     <= hold_in;
         baseline_ff <= baseline_in;
         dep_one_ff  <= dep_one_in;
         dep_two_ff  <= dep_two_in;
         status_ff   <= status_in;
         rail_ff     <= rail_in;
         burn_one_ff <= burn_one_in;
         burn_two_ff <= burn_two_in;
         ant_ff      <= ant_in;
      end
   end

   // Response register: valid flag and the per-beat extras
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_finished_ff <= finished_in;
         rsp_status_ff   <= status_out_in;
      end
   end

   // Level fields come straight from the state, which only moves on accept
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.rail_enable    = rail_ff;
   assign rsp_bus.burn_one       = burn_one_ff;
   assign rsp_bus.burn_two       = burn_two_ff;
   assign rsp_bus.active_antenna = ant_ff;
   assign rsp_bus.deploy_status  = rsp_status_ff;
   assign rsp_bus.finished       = rsp_finished_ff;
   assign rsp_bus.busy_res       = (phase_ff != PH_IDLE);

endmodule

[tb/tb_top.sv]
module tb_top
   import ads_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;

   // Sequencer phases as tracked by the predictor
   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_SENSE,
      SEQ_HOLD_ON,
      SEQ_HOLD_OFF,
      SEQ_GAP
   } seq_phase_type;

   typedef struct packed {
      logic                rail_enable;
      logic                burn_one;
      logic                burn_two;
      logic [ANT_W-1:0]    active_antenna;
      logic [STATUS_W-1:0] deploy_status;
      logic                finished;
      logic                busy_res;
   } deploy_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ads_req_if req_bus ();
   ads_rsp_if rsp_bus ();

   antenna_deploy_sequencer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Register copies
   logic [TOL_W-1:0]   cfg_tol;
   logic [TICKS_W-1:0] cfg_hold;
   logic [RETRY_W-1:0] cfg_retries;

   // Sequencer state copy
   seq_phase_type       m_phase;
   logic [RETRY_W-1:0]  m_attempts;
   logic [HOLD_BITS-1:0] m_hold;
   logic [CLASS_W-1:0]  m_baseline;
   logic                m_dep_one;
   logic                m_dep_two;
   logic [CLASS_W-1:0]  m_status;
   logic                m_rail;
   logic                m_burn_one;
   logic                m_burn_two;
   logic [ANT_W-1:0]    m_antenna;

   deploy_result_type pending_status[$];
   int mismatches = 0;
   int beats_seen = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int rsp_hold_left = 0;

   // ---------------------------------------------------------------- predictor

   function automatic logic [TOL_W-1:0] eff_tol();
      return (cfg_tol >= TOL_MIN && cfg_tol <= TOL_MAX) ? cfg_tol : TOL_MIN;
   endfunction

   function automatic logic [CLASS_W-1:0] band_of(input logic [SENSE_W-1:0] mv);
      logic [TOL_W-1:0] tol;
      tol = eff_tol();
      if (mv < EDGE_LOW - tol) return CLS_NONE;
      if (mv < EDGE_MID - tol) return CLS_ONE;
      if (mv < EDGE_HIGH - tol) return CLS_TWO;
      return CLS_BOTH;
   endfunction

   // deployed flags are sticky; status follows the latest band
   function automatic void mark_band(input logic [CLASS_W-1:0] cls);
      if (cls == CLS_ONE || cls == CLS_BOTH) m_dep_one = 1'b1;
      if (cls == CLS_TWO || cls == CLS_BOTH) m_dep_two = 1'b1;
      if (cls != CLS_NONE) m_status = cls;
   endfunction

   // one tick of a hold; saturating counter also ends it
   function automatic logic hold_step();
      if (int'(m_hold) + 1 >= int'(cfg_hold) || m_hold == '1) begin
         m_hold = '0;
         return 1'b1;
      end
      m_hold = m_hold + 1'b1;
      return 1'b0;
   endfunction

   function automatic logic leave_antenna(input logic [ANT_W-1:0] ant);
      m_antenna  = ANT_NONE;
      m_attempts = '0;
      m_hold     = '0;
      if (ant == ANT_ONE) begin
         m_burn_one = 1'b0;
         m_phase    = SEQ_GAP;
         return 1'b0;
      end
      m_burn_two = 1'b0;
      m_rail     = 1'b0;
      m_phase    = SEQ_IDLE;
      return 1'b1;
   endfunction

   function automatic logic enter_antenna(input logic [ANT_W-1:0] ant);
      if ((ant == ANT_ONE) ? m_dep_one : m_dep_two) return leave_antenna(ant);
      m_antenna = ant;
      if (ant == ANT_ONE) m_burn_one = 1'b1;
      else m_burn_two = 1'b1;
      m_phase = SEQ_SENSE;
      return 1'b0;
   endfunction

   task automatic deploy_predict(input logic op, input logic [SENSE_W-1:0] mv,
                                 input logic [STACKS_W-1:0] st,
                                 output deploy_result_type res);
      logic fin;
      logic refused;
      logic [CLASS_W-1:0] cls;
      logic [ANT_W-1:0] ant;
      fin = 1'b0;
      refused = 1'b0;
      ant = (m_antenna == ANT_TWO) ? ANT_TWO : ANT_ONE;
      if (op == OP_START) begin
         if (m_phase == SEQ_IDLE) begin
            if (st <= STACKS_REFUSE_MAX) begin
               refused = 1'b1;
               fin = 1'b1;
            end else begin
               m_baseline = band_of(mv);
               mark_band(m_baseline);
               m_attempts = '0;
               m_hold = '0;
               m_rail = 1'b1;
               m_burn_one = 1'b0;
               m_burn_two = 1'b0;
               fin = enter_antenna(ANT_ONE);
            end
         end
      end else begin
         case (m_phase)
            SEQ_SENSE: begin
               cls = band_of(mv);
               mark_band(cls);
               if (cls != m_baseline || m_attempts == cfg_retries) begin
                  fin = leave_antenna(ant);
               end else begin
                  m_attempts = m_attempts + 1'b1;
                  m_hold = '0;
                  m_phase = SEQ_HOLD_ON;
               end
            end
            SEQ_HOLD_ON: begin
               if (hold_step()) begin
                  m_burn_one = 1'b0;
                  m_burn_two = 1'b0;
                  m_phase = SEQ_HOLD_OFF;
               end
            end
            SEQ_HOLD_OFF: begin
               if (hold_step()) fin = enter_antenna(ant);
            end
            SEQ_GAP: begin
               if (hold_step()) fin = enter_antenna(ANT_TWO);
            end
            default: ;
         endcase
      end
      res.rail_enable    = m_rail;
      res.burn_one       = m_burn_one;
      res.burn_two       = m_burn_two;
      res.active_antenna = m_antenna;
      res.deploy_status  = refused ? STATUS_REFUSED : {1'b0, m_status};
      res.finished       = fin;
      res.busy_res       = (m_phase != SEQ_IDLE);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic note_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 60)
         $display("tb_top: ERROR beat %0d %s got %0d want %0d (cycle %0d)",
                  beats_seen, what, got, want, cycle_count);
   endtask

   task automatic compare_result(input deploy_result_type got,
                                 input deploy_result_type want);
      if (got.rail_enable != want.rail_enable)
         note_mismatch("rail_enable", got.rail_enable, want.rail_enable);
      if (got.burn_one != want.burn_one)
         note_mismatch("burn_one", got.burn_one, want.burn_one);
      if (got.burn_two != want.burn_two)
         note_mismatch("burn_two", got.burn_two, want.burn_two);
      if (got.active_antenna != want.active_antenna)
         note_mismatch("active_antenna", got.active_antenna, want.active_antenna);
      if (got.deploy_status != want.deploy_status)
         note_mismatch("deploy_status", got.deploy_status, want.deploy_status);
      if (got.finished != want.finished)
         note_mismatch("finished", got.finished, want.finished);
      if (got.busy_res != want.busy_res)
         note_mismatch("busy_res", got.busy_res, want.busy_res);
   endtask

   // predict on accepted requests, then check accepted responses
   always @(posedge clock) begin
      deploy_result_type got;
      deploy_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("antenna_deploy_sequencer_top: mismatch");
         $finish;
      end else if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_TOLERANCE:   cfg_tol = csr_wdata[TOL_W-1:0];
               CSR_HOLD_TICKS:  cfg_hold = csr_wdata[TICKS_W-1:0];
               CSR_MAX_RETRIES: cfg_retries = csr_wdata[RETRY_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            deploy_predict(req_bus.op, req_bus.sense_mv, req_bus.battery_stacks, want);
            pending_status.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            beats_seen++;
            got.rail_enable    = rsp_bus.rail_enable;
            got.burn_one       = rsp_bus.burn_one;
            got.burn_two       = rsp_bus.burn_two;
            got.active_antenna = rsp_bus.active_antenna;
            got.deploy_status  = rsp_bus.deploy_status;
            got.finished       = rsp_bus.finished;
            got.busy_res       = rsp_bus.busy_res;
            if (pending_status.size() == 0) begin
               note_mismatch("unexpected beat", 1, 0);
            end else begin
               want = pending_status.pop_front();
               compare_result(got, want);
            end
         end
      end
   end

   // response ready: random idling, or a long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- drivers

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_beat(input logic op, input logic [SENSE_W-1:0] mv,
                            input logic [STACKS_W-1:0] st);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.op             <= op;
      req_bus.sense_mv       <= mv;
      req_bus.battery_stacks <= st;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_status.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // only called with the sequencer idle
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] tol,
                                input logic [CSR_DATA_W-1:0] hold,
                                input logic [CSR_DATA_W-1:0] retries);
      drain_results();
      write_csr(CSR_TOLERANCE, tol);
      write_csr(CSR_HOLD_TICKS, hold);
      write_csr(CSR_MAX_RETRIES, retries);
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [CSR_DATA_W-1:0] pick_tol();
      case ($urandom_range(11))
         0: return 16'd0;
         1: return 16'd199;
         2: return 16'd200;
         3: return 16'd201;
         4: return 16'd300;
         5: return 16'd399;
         6: return 16'd400;
         7: return 16'd401;
         8: return 16'd1000;
         9: return 16'd1023;
         default: return 16'($urandom_range(1023));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_hold();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'($urandom_range(8, 5));
         default: return 16'($urandom_range(4, 1));
      endcase
   endfunction

   function automatic logic [STACKS_W-1:0] pick_stacks();
      if ($urandom_range(4) == 0) return 4'($urandom_range(15));
      return 4'($urandom_range(15, 2));
   endfunction

   // sample in a band no higher than top, biased to the band edges
   function automatic logic [SENSE_W-1:0] band_sample(input int top);
      int lo;
      int hi;
      int e0;
      int e1;
      int e2;
      e0 = int'(EDGE_LOW) - int'(eff_tol());
      e1 = int'(EDGE_MID) - int'(eff_tol());
      e2 = int'(EDGE_HIGH) - int'(eff_tol());
      case ($urandom_range(top))
         0: begin lo = 0;  hi = e0 - 1; end
         1: begin lo = e0; hi = e1 - 1; end
         2: begin lo = e1; hi = e2 - 1; end
         default: begin lo = e2; hi = 4095; end
      endcase
      case ($urandom_range(3))
         0: return 12'(lo);
         1: return 12'(hi);
         default: return 12'($urandom_range(hi, lo));
      endcase
   endfunction

   // keep classified samples within the allowed bands, so that with top 0 the flags stay clear
   function automatic logic [SENSE_W-1:0] pick_sense(input logic op,
                                                    input logic [STACKS_W-1:0] st,
                                                    input int top);
      if ((op == OP_START && m_phase == SEQ_IDLE && st > STACKS_REFUSE_MAX) ||
          (op == OP_TICK && m_phase == SEQ_SENSE))
         return band_sample(top);
      return 12'($urandom_range(4095));
   endfunction

   task automatic finish_sequence(input int top);
      while (m_phase != SEQ_IDLE)
         send_beat(OP_TICK, pick_sense(OP_TICK, 4'd0, top), 4'($urandom_range(15)));
   endtask

   task automatic run_items(input int count, input int top, input int pause_at);
      int k;
      logic op;
      logic [STACKS_W-1:0] st;
      for (k = 0; k < count; k++) begin
         if (k == pause_at) drain_results();
         if (m_phase == SEQ_IDLE) op = ($urandom_range(9) < 8) ? OP_START : OP_TICK;
         else op = ($urandom_range(24) == 0) ? OP_START : OP_TICK;
         st = pick_stacks();
         send_beat(op, pick_sense(op, st, top), st);
      end
      finish_sequence(top);
   endtask

   // ---------------------------------------------------------------- tests

   // reset register values: tolerance 200, hold 1000, two retries
   task automatic test_reset_defaults();
      int n;
      send_beat(OP_START, 12'hFFF, 4'd0);
      send_beat(OP_START, 12'd0, 4'd1);
      send_beat(OP_TICK, 12'hFFF, 4'hF);
      send_beat(OP_START, 12'd459, 4'hF);
      // first try stays in the lowest band, then part of a full-length hold
      send_beat(OP_TICK, 12'd459, 4'hF);
      for (n = 0; n < 24; n++)
         send_beat(OP_TICK, 12'($urandom_range(4095)), 4'hF);
      // shorten the hold so the remaining tries run quickly; start while busy
      drain_results();
      write_csr(CSR_HOLD_TICKS, 16'd1);
      send_beat(OP_START, 12'd0, 4'd2);
      finish_sequence(0);
   endtask

   task automatic test_directed_cases();
      // tolerance below the window, zero-length hold, most retries
      apply_setting(16'd0, 16'd0, 16'd3);
      send_beat(OP_START, 12'd459, 4'd2);
      send_beat(OP_START, 12'hFFF, 4'd0);
      finish_sequence(0);
      // tolerance above the window, no retries, tick while idle
      apply_setting(16'd1023, 16'd1, 16'd0);
      send_beat(OP_TICK, 12'hFFF, 4'hF);
      send_beat(OP_START, 12'd0, 4'd3);
      finish_sequence(0);
      // top of the window
      apply_setting(16'd400, 16'd2, 16'd1);
      send_beat(OP_START, 12'd259, 4'hF);
      finish_sequence(0);
      // upper data bits are not part of the tolerance
      apply_setting(16'hFD2C, 16'd1, 16'd2);
      send_beat(OP_START, 12'd359, 4'd7);
      finish_sequence(0);
      send_beat(OP_START, 12'd0, 4'd1);
      send_beat(OP_START, 12'hAAA, 4'd0);
   endtask

   // flags stay clear: every classification lands in the lowest band
   task automatic test_retry_loops();
      int s;
      for (s = 0; s < 4; s++) begin
         apply_setting(pick_tol(), pick_hold(), 16'($urandom_range(3)));
         run_items(120, 0, -1);
      end
   endtask

   // first band allowed: class changes end tries, antenna 1 gets skipped
   task automatic test_band_changes();
      int s;
      for (s = 0; s < 4; s++) begin
         apply_setting(pick_tol(), pick_hold(), 16'($urandom_range(3)));
         run_items(100, 1, 50);
      end
   endtask

   task automatic test_all_bands();
      int t;
      int e;
      int edge_mv;
      int tol;
      // band edges at both ends of the tolerance window
      for (t = 0; t < 2; t++) begin
         tol = (t == 0) ? int'(TOL_MIN) : int'(TOL_MAX);
         apply_setting(16'(tol), 16'd1, 16'($urandom_range(3)));
         for (e = 0; e < 3; e++) begin
            edge_mv = (e == 0) ? int'(EDGE_LOW) : (e == 1) ? int'(EDGE_MID) : int'(EDGE_HIGH);
            send_beat(OP_START, 12'(edge_mv - tol - 1), 4'd2);
            finish_sequence(3);
            send_beat(OP_START, 12'(edge_mv - tol), 4'd2);
            finish_sequence(3);
         end
      end
      // long receiver hold-off while requests keep coming
      apply_setting(pick_tol(), pick_hold(), 16'($urandom_range(3)));
      @(posedge clock);
      rsp_hold_left = 300;
      @(negedge clock);
      run_items(80, 3, -1);
      for (t = 0; t < 3; t++) begin
         apply_setting(pick_tol(), pick_hold(), 16'($urandom_range(3)));
         run_items(100, 3, 40);
      end
   endtask

   // longest hold setting: run well into the gap, then shorten it to finish
   task automatic test_saturating_hold();
      int n;
      apply_setting(16'd300, 16'hFFFF, 16'd0);
      send_beat(OP_START, band_sample(3), 4'd2);
      for (n = 0; n < 40; n++)
         send_beat(OP_TICK, band_sample(3), 4'hF);
      drain_results();
      write_csr(CSR_HOLD_TICKS, 16'd1);
      finish_sequence(3);
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_START;
      req_bus.sense_mv = '0;
      req_bus.battery_stacks = '0;
      rsp_bus.ready = 1'b0;
      cfg_tol = TOL_RESET;
      cfg_hold = TICKS_RESET;
      cfg_retries = RETRIES_RESET;
      m_phase = SEQ_IDLE;
      m_attempts = '0;
      m_hold = '0;
      m_baseline = CLS_NONE;
      m_dep_one = 1'b0;
      m_dep_two = 1'b0;
      m_status = CLS_NONE;
      m_rail = 1'b0;
      m_burn_one = 1'b0;
      m_burn_two = 1'b0;
      m_antenna = ANT_NONE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 32;
      rcv_idle_pct = 72;
      test_reset_defaults();
      test_directed_cases();
      test_retry_loops();

      send_idle_pct = 72;
      rcv_idle_pct = 32;
      test_band_changes();

      send_idle_pct = 0;
      rcv_idle_pct = 0;
      test_all_bands();
      test_saturating_hold();

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_status.size() == 0) begin
         $display("antenna_deploy_sequencer_top: match");
      end else begin
         $display("antenna_deploy_sequencer_top: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ads_pkg.sv
rtl/ads_if.sv
rtl/antenna_deploy_sequencer_top.sv
tb/tb_top.sv
